### hw/rtl/rv3d_pkg.sv
// Shared widths, sine coefficients and rounding multiply for the 3D rotation pipeline.
package rv3d_pkg;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int TRIG_W  = 32;
    localparam int AB_W    = COORD_W + 2;
    localparam int C_W     = COORD_W + 3;
    localparam int WIDE_W  = COORD_W + 4;
    localparam int N_TRIG  = 6;
    localparam int TRIG_ST = 8;
    localparam int N_ST    = TRIG_ST + 6;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [61:0] HALF_Q30 = 62'h2000_0000;

    localparam logic [30:0] SIN_COEF [7] = '{
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
        31'd172272, 31'd3864, 31'd61
    };

    // round(v*s / 2^30), ties away from zero
    function automatic logic signed [WIDE_W-1:0] trig_mul(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [TRIG_W-1:0] s
    );
        logic                        neg;
        logic [WIDE_W-1:0]           mv;
        logic [TRIG_W-2:0]           ms;
        logic [WIDE_W+TRIG_W-1:0]    p;
        logic [WIDE_W+TRIG_W-1:0]    r;
        neg = v[WIDE_W-1] ^ s[TRIG_W-1];
        mv  = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        ms  = s[TRIG_W-1] ? (TRIG_W-1)'(-s) : (TRIG_W-1)'(s);
        p   = (WIDE_W+TRIG_W)'(mv) * (WIDE_W+TRIG_W)'(ms);
        r   = (p + (WIDE_W+TRIG_W)'(HALF_Q30)) >> 30;
        return neg ? -$signed(r[WIDE_W-1:0]) : $signed(r[WIDE_W-1:0]);
    endfunction

endpackage

### hw/rtl/rotate_vector_3d_euler.sv
// Pipelined Euler-angle (Z, Y, X) rotation of a Q16.16 vector with polynomial sine/cosine.
//
//  channel | ports              | role
//  s_      | valid/ready + 6    | vector and three angles in
//  m_      | valid/ready + 3    | rotated, saturated vector out
//
// One beat per cycle sustained while m_ready stays high.
// Stages 0-7 evaluate six sine/cosine polynomials (Horner steps in stages 1-6),
// stages 8-13 do the three rotations, one multiply rank then one add rank each.
// Each stage holds its beat when the next one is full and stalled; empty
// stages keep filling. Reset clears the valid bits only.
module rotate_vector_3d_euler (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [rv3d_pkg::COORD_W-1:0]    s_in_x,
    input  logic signed [rv3d_pkg::COORD_W-1:0]    s_in_y,
    input  logic signed [rv3d_pkg::COORD_W-1:0]    s_in_z,
    input  logic        [rv3d_pkg::ANGLE_W-1:0]    s_angle_x,
    input  logic        [rv3d_pkg::ANGLE_W-1:0]    s_angle_y,
    input  logic        [rv3d_pkg::ANGLE_W-1:0]    s_angle_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [rv3d_pkg::COORD_W-1:0]    m_out_x,
    output logic signed [rv3d_pkg::COORD_W-1:0]    m_out_y,
    output logic signed [rv3d_pkg::COORD_W-1:0]    m_out_z
);

    localparam int CW = rv3d_pkg::COORD_W;
    localparam int AW = rv3d_pkg::ANGLE_W;
    localparam int TW = rv3d_pkg::TRIG_W;
    localparam int WW = rv3d_pkg::WIDE_W;
    localparam int NT = rv3d_pkg::N_TRIG;
    localparam int NS = rv3d_pkg::N_ST;
    localparam int TS = rv3d_pkg::TRIG_ST;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // trig section
    logic        [30:0]        t_reg   [0:TS-2][NT];
    logic        [30:0]        t2_reg  [0:TS-2][NT];
    logic                      neg_reg [0:TS-2][NT];
    logic        [30:0]        acc_reg [1:TS-2][NT];
    logic signed [TW-1:0]      trig_reg[TS-1:NS-3][NT];
    logic signed [CW-1:0]      xyz_reg [0:TS-1][3];

    logic        [30:0]        t_next   [NT];
    logic        [30:0]        t2_next  [NT];
    logic                      neg_next [NT];
    logic        [30:0]        acc_next [1:TS-2][NT];
    logic signed [TW-1:0]      trig_next[NT];

    // rotation section
    logic signed [WW-1:0] p8_reg [4];
    logic signed [CW-1:0] z8_reg, z9_reg;
    logic signed [WW-1:0] a9_reg, b9_reg;
    logic signed [WW-1:0] p10_reg [4];
    logic signed [WW-1:0] b10_reg, b11_reg;
    logic signed [WW-1:0] c11_reg, ox11_reg;
    logic signed [WW-1:0] p12_reg [4];
    logic signed [WW-1:0] ox12_reg;
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [WW-1:0] oy_full, oz_full;

    logic [AW-1:0] ang [3];

    assign ang[0] = s_angle_x;
    assign ang[1] = s_angle_y;
    assign ang[2] = s_angle_z;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS-2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];

    // unit u: angle u/2, cosine when u is odd
    always_comb begin
        for (int u = 0; u < NT; u++) begin
            logic [31:0] ph;
            logic [1:0]  quad;
            logic [30:0] t;
            logic [61:0] sq;
            logic [61:0] sqr;
            ph   = {ang[u/2], {(32-AW){1'b0}}};
            quad = ph[31:30] + {1'b0, u[0]};
            t    = {1'b0, ph[29:0]};
            if (quad[0]) begin
                t = rv3d_pkg::ONE_Q30 - t;
            end
            sq  = 62'(t) * 62'(t);
            sqr = (sq + rv3d_pkg::HALF_Q30) >> 30;
            t_next[u]   = t;
            t2_next[u]  = sqr[30:0];
            neg_next[u] = quad[1];
        end
    end

    always_comb begin
        for (int h = 1; h <= TS-2; h++) begin
            for (int u = 0; u < NT; u++) begin
                logic [30:0]        ain;
                logic [61:0]        pr;
                logic [61:0]        rq;
                logic signed [32:0] df;
                ain = (h == 1) ? rv3d_pkg::SIN_COEF[6] : acc_reg[(h == 1) ? 1 : h-1][u];
                pr  = 62'(ain) * 62'(t2_reg[h-1][u]);
                rq  = (pr + rv3d_pkg::HALF_Q30) >> 30;
                df  = $signed({2'b00, rv3d_pkg::SIN_COEF[6-h]}) - $signed({1'b0, rq[31:0]});
                acc_next[h][u] = df[32] ? 31'd0 : df[30:0];
            end
        end
    end

    always_comb begin
        for (int u = 0; u < NT; u++) begin
            logic [61:0] pr;
            logic [61:0] f;
            logic [30:0] fc;
            pr = 62'(acc_reg[TS-2][u]) * 62'(t_reg[TS-2][u]);
            f  = (pr + rv3d_pkg::HALF_Q30) >> 30;
            fc = (f > 62'(rv3d_pkg::ONE_Q30)) ? rv3d_pkg::ONE_Q30 : f[30:0];
            trig_next[u] = neg_reg[TS-2][u] ? -$signed({1'b0, fc}) : $signed({1'b0, fc});
        end
    end

    function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        hi = WW'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - WW'(1);
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    assign oy_full = p12_reg[0] + p12_reg[1];
    assign oz_full = p12_reg[2] - p12_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? s_valid : v_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg[0]   <= t_next;
            t2_reg[0]  <= t2_next;
            neg_reg[0] <= neg_next;
            xyz_reg[0][0] <= s_in_x;
            xyz_reg[0][1] <= s_in_y;
            xyz_reg[0][2] <= s_in_z;
        end
        for (int h = 1; h <= TS-2; h++) begin
            if (en[h]) begin
                t_reg[h]   <= t_reg[h-1];
                t2_reg[h]  <= t2_reg[h-1];
                neg_reg[h] <= neg_reg[h-1];
                acc_reg[h] <= acc_next[h];
            end
        end
        for (int h = 1; h <= TS-1; h++) begin
            if (en[h]) begin
                xyz_reg[h] <= xyz_reg[h-1];
            end
        end
        if (en[TS-1]) begin
            trig_reg[TS-1] <= trig_next;
        end
        for (int h = TS; h <= NS-3; h++) begin
            if (en[h]) begin
                trig_reg[h] <= trig_reg[h-1];
            end
        end
        // unit order: sx cx sy cy sz cz
        if (en[TS]) begin
            p8_reg[0] <= rv3d_pkg::trig_mul(WW'(xyz_reg[TS-1][1]), trig_reg[TS-1][4]);
            p8_reg[1] <= rv3d_pkg::trig_mul(WW'(xyz_reg[TS-1][0]), trig_reg[TS-1][5]);
            p8_reg[2] <= rv3d_pkg::trig_mul(WW'(xyz_reg[TS-1][1]), trig_reg[TS-1][5]);
            p8_reg[3] <= rv3d_pkg::trig_mul(WW'(xyz_reg[TS-1][0]), trig_reg[TS-1][4]);
            z8_reg    <= xyz_reg[TS-1][2];
        end
        if (en[TS+1]) begin
            a9_reg <= p8_reg[0] + p8_reg[1];
            b9_reg <= p8_reg[2] - p8_reg[3];
            z9_reg <= z8_reg;
        end
        if (en[TS+2]) begin
            p10_reg[0] <= rv3d_pkg::trig_mul(WW'(z9_reg), trig_reg[TS+1][3]);
            p10_reg[1] <= rv3d_pkg::trig_mul(a9_reg, trig_reg[TS+1][2]);
            p10_reg[2] <= rv3d_pkg::trig_mul(a9_reg, trig_reg[TS+1][3]);
            p10_reg[3] <= rv3d_pkg::trig_mul(WW'(z9_reg), trig_reg[TS+1][2]);
            b10_reg    <= b9_reg;
        end
        if (en[TS+3]) begin
            c11_reg  <= p10_reg[0] + p10_reg[1];
            ox11_reg <= p10_reg[2] - p10_reg[3];
            b11_reg  <= b10_reg;
        end
        if (en[TS+4]) begin
            p12_reg[0] <= rv3d_pkg::trig_mul(c11_reg, trig_reg[TS+3][0]);
            p12_reg[1] <= rv3d_pkg::trig_mul(b11_reg, trig_reg[TS+3][1]);
            p12_reg[2] <= rv3d_pkg::trig_mul(c11_reg, trig_reg[TS+3][1]);
            p12_reg[3] <= rv3d_pkg::trig_mul(b11_reg, trig_reg[TS+3][0]);
            ox12_reg   <= ox11_reg;
        end
        if (en[NS-1]) begin
            ox_reg <= sat(ox12_reg);
            oy_reg <= sat(oy_full);
            oz_reg <= sat(oz_full);
        end
    end

    assign m_out_x = ox_reg;
    assign m_out_y = oy_reg;
    assign m_out_z = oz_reg;

`ifndef SYNTHESIS
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[NS-1] |-> s_ready)
        else $error("input stalled with empty output stage");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[TS-1] |-> (trig_reg[TS-1][0] <= $signed({1'b0, rv3d_pkg::ONE_Q30}))
                     && (trig_reg[TS-1][0] >= -$signed({1'b0, rv3d_pkg::ONE_Q30})))
        else $error("sine out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NS-1] && !m_ready |=> v_reg[NS-1] && $stable(ox_reg))
        else $error("stalled output beat lost");
`endif

endmodule

### bench/rotate_vector_3d_euler_tb.sv
// Self-checking testbench for the Euler-angle 3D vector rotation pipeline.
`timescale 1ns / 1ps
module rotate_vector_3d_euler_tb;

    localparam int LATENCY   = 14;
    localparam int N_RANDOM  = 550;
    localparam int MAX_CYC   = 400000;

    typedef struct {
        logic signed [rv3d_pkg::COORD_W-1:0] x, y, z;
        logic [rv3d_pkg::ANGLE_W-1:0]        ax, ay, az;
    } vec_in_t;

    typedef struct {
        logic signed [rv3d_pkg::COORD_W-1:0] x, y, z;
    } vec_out_t;

    typedef struct {
        vec_in_t  v;
        bit       has_exp;
        vec_out_t e;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [rv3d_pkg::COORD_W-1:0] s_in_x = '0, s_in_y = '0, s_in_z = '0;
    logic [rv3d_pkg::ANGLE_W-1:0] s_angle_x = '0, s_angle_y = '0, s_angle_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [rv3d_pkg::COORD_W-1:0] m_out_x, m_out_y, m_out_z;

    vec_out_t rotated_q[$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 1'b0;

    always #5 aclk = ~aclk;

    rotate_vector_3d_euler DUT (.*);

    // sin(pi/2*t), t in Q1.30
    function automatic longint quarter_sin(longint t);
        longint coef[7] = '{1686629713, 693598668, 85569306, 5026995, 172272, 3864, 61};
        longint t2, acc;
        t2 = (t * t + (64'sd1 << 29)) >>> 30;
        acc = coef[6];
        for (int k = 5; k >= 0; k--) begin
            acc = coef[k] - ((acc * t2 + (64'sd1 << 29)) >>> 30);
            if (acc < 0) acc = 0;
        end
        acc = (acc * t + (64'sd1 << 29)) >>> 30;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        return acc;
    endfunction

    function automatic longint phase_sin(logic [31:0] ph);
        longint t, f;
        t = longint'(ph[29:0]);
        if (ph[30]) t = (64'sd1 << 30) - t;
        f = quarter_sin(t);
        return ph[31] ? -f : f;
    endfunction

    // round(v*s/2^30), ties away from zero, exact in 128 bits
    function automatic longint rmul(longint v, longint s);
        logic [127:0] mv, ms, p;
        bit neg;
        neg = (v < 0) != (s < 0);
        mv = (v < 0) ? 128'(-v) : 128'(v);
        ms = (s < 0) ? 128'(-s) : 128'(s);
        p = (mv * ms + (128'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [rv3d_pkg::COORD_W-1:0] clamp(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (rv3d_pkg::COORD_W - 1)) - 1;
        lo = -(64'sd1 <<< (rv3d_pkg::COORD_W - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[rv3d_pkg::COORD_W-1:0];
    endfunction

    function automatic vec_out_t rotate_zyx(vec_in_t v);
        logic [31:0] px, py, pz;
        longint sx, cx, sy, cy, sz, cz, a, b, c;
        vec_out_t r;
        px = {v.ax, 16'h0};
        py = {v.ay, 16'h0};
        pz = {v.az, 16'h0};
        sx = phase_sin(px); cx = phase_sin(px + 32'h4000_0000);
        sy = phase_sin(py); cy = phase_sin(py + 32'h4000_0000);
        sz = phase_sin(pz); cz = phase_sin(pz + 32'h4000_0000);
        a = rmul(v.y, sz) + rmul(v.x, cz);
        b = rmul(v.y, cz) - rmul(v.x, sz);
        c = rmul(v.z, cy) + rmul(a, sy);
        r.x = clamp(rmul(a, cy) - rmul(v.z, sy));
        r.y = clamp(rmul(c, sx) + rmul(b, cx));
        r.z = clamp(rmul(c, cx) - rmul(b, sx));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_beat(vec_in_t v);
        int g;
        s_valid   <= 1'b1;
        s_in_x    <= v.x;  s_in_y    <= v.y;  s_in_z    <= v.z;
        s_angle_x <= v.ax; s_angle_y <= v.ay; s_angle_z <= v.az;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rotated_q.push_back(rotate_zyx(v));
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic vec_in_t mk(int x, int y, int z, int ax, int ay, int az);
        vec_in_t v;
        v.x = x; v.y = y; v.z = z;
        v.ax = 16'(ax); v.ay = 16'(ay); v.az = 16'(az);
        return v;
    endfunction

    function automatic vec_out_t mo(int x, int y, int z);
        vec_out_t o;
        o.x = x; o.y = y; o.z = z;
        return o;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            1: return {$urandom_range(0, 1) ? 2'b11 : 2'b00, 30'($urandom)};
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                            : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rnd_angle();
        if ($urandom_range(0, 5) == 0) return 16'($urandom_range(0, 3)) << 14;
        return 16'($urandom);
    endfunction

    dir_row_t directed[$];

    initial begin
        vec_in_t v;
        directed.push_back('{mk(0, 0, 0, 0, 0, 0), 1, mo(0, 0, 0)});
        directed.push_back('{mk(32'h10000, 32'h20000, 32'h30000, 0, 0, 0), 1,
                             mo(32'h10000, 32'h20000, 32'h30000)});
        directed.push_back('{mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0), 1,
                             mo(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF)});
        directed.push_back('{mk(32'h10000, 0, 0, 0, 0, 16'h4000), 1, mo(0, -32'h10000, 0)});
        directed.push_back('{mk(32'h10000, 0, 0, 0, 0, 16'h8000), 1, mo(-32'h10000, 0, 0)});
        directed.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                16'h2000, 16'h2000, 16'h2000), 0, mo(0, 0, 0)});
        directed.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000,
                                16'hE000, 16'h6000, 16'hA000), 0, mo(0, 0, 0)});
        directed.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 16'h2000), 0,
                             mo(0, 0, 0)});
        for (int q = 0; q < 4; q++)
            directed.push_back('{mk(32'h12345, -32'h23456, 32'h34567, q << 14,
                                    ((q + 1) % 4) << 14, ((q + 2) % 4) << 14), 0, mo(0, 0, 0)});
        directed.push_back('{mk(-1, 1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, mo(0, 0, 0)});
        directed.push_back('{mk(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
                                16'h5555, 16'hAAAA, 16'h0001), 0, mo(0, 0, 0)});
        directed.push_back('{mk(32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0,
                                16'hAAAA, 16'h5555, 16'h8001), 0, mo(0, 0, 0)});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_beat(directed[i].v);
            if (directed[i].has_exp) rotated_q[$] = directed[i].e;
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            v.x = rnd_coord(); v.y = rnd_coord(); v.z = rnd_coord();
            v.ax = rnd_angle(); v.ay = rnd_angle(); v.az = rnd_angle();
            send_beat(v);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Output side: random stalls, with quiet stretches of none
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 2);
        if (stall_mode == 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 9) < (stall_mode == 1 ? 7 : 2));
    end

    always @(posedge aclk) begin
        vec_out_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (rotated_q.size() == 0) begin
                report_mismatch("unexpected beat", m_out_x, 32'h0);
            end else begin
                e = rotated_q.pop_front();
                if (m_out_x !== e.x) report_mismatch("out_x", m_out_x, e.x);
                if (m_out_y !== e.y) report_mismatch("out_y", m_out_y, e.y);
                if (m_out_z !== e.z) report_mismatch("out_z", m_out_z, e.z);
            end
        end
    end

    initial begin
        wait (stim_done);
        while (rotated_q.size() != 0 && cycles < MAX_CYC) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (cycles >= MAX_CYC) begin
            $display("rotate_vector_3d_euler verification failed");
        end else if (errors == 0 && rotated_q.size() == 0) begin
            $display("rotate_vector_3d_euler verification clean");
        end else begin
            $display("rotate_vector_3d_euler verification failed");
        end
        $finish;
    end

    initial begin
        wait (cycles >= MAX_CYC + LATENCY + 20);
        $display("rotate_vector_3d_euler verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rv3d_pkg.sv
hw/rtl/rotate_vector_3d_euler.sv
bench/rotate_vector_3d_euler_tb.sv
